>>> rtl/tcphf_pkg.sv
// Shared types and constants for the TCP header filter with statistics counters.
package tcphf_pkg;

	// Field widths fixed by the packet formats
	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned PORT_W      = 16;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned NIBBLE_W    = 4;
	localparam int unsigned VALUE_W     = 64;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_ADDR_W  = 2;
	localparam int unsigned IN_DATA_W   = 152;
	localparam int unsigned OUT_DATA_W  = 80;

	// Statistics counter bank
	localparam int unsigned NUM_COUNTERS = 11;
	localparam int unsigned CIDX_W       = 4;
	localparam logic [CIDX_W-1:0] C_SEEN      = 4'd0;
	localparam logic [CIDX_W-1:0] C_TCP       = 4'd1;
	localparam logic [CIDX_W-1:0] C_IPBYTES   = 4'd2;
	localparam logic [CIDX_W-1:0] C_PAYLOAD   = 4'd3;
	localparam logic [CIDX_W-1:0] C_SYN       = 4'd4;
	localparam logic [CIDX_W-1:0] C_ACK       = 4'd5;
	localparam logic [CIDX_W-1:0] C_FIN       = 4'd6;
	localparam logic [CIDX_W-1:0] C_RST       = 4'd7;
	localparam logic [CIDX_W-1:0] C_PSH       = 4'd8;
	localparam logic [CIDX_W-1:0] C_FILTERED  = 4'd9;
	localparam logic [CIDX_W-1:0] C_MALFORMED = 4'd10;

	// TCP flag bit positions
	localparam int unsigned FLAG_FIN = 0;
	localparam int unsigned FLAG_SYN = 1;
	localparam int unsigned FLAG_RST = 2;
	localparam int unsigned FLAG_PSH = 3;
	localparam int unsigned FLAG_ACK = 4;

	// Header constants
	localparam logic [BYTE_W-1:0]   BASE_HDR_BYTES = 8'd20;
	localparam logic [NIBBLE_W-1:0] IP_VERSION_4   = 4'd4;
	localparam logic [BYTE_W-1:0]   PROTO_TCP      = 8'd6;

	// Request opcodes
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SRC_ADDR = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DST_ADDR = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SRC_PORT = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DST_PORT = 2'd3;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		CLASS_IGNORED   = 2'd0,
		CLASS_FILTERED  = 2'd1,
		CLASS_MALFORMED = 2'd2,
		CLASS_COUNTED   = 2'd3
	} class_t;

	// Unpacked input request
	typedef struct packed {
		logic                opcode;
		logic [BYTE_W-1:0]   captured_length;
		logic [BYTE_W-1:0]   version_and_ihl;
		logic [BYTE_W-1:0]   ip_protocol;
		logic [ADDR_W-1:0]   src_addr;
		logic [ADDR_W-1:0]   dst_addr;
		logic [LEN_W-1:0]    total_length;
		logic [PORT_W-1:0]   src_port;
		logic [PORT_W-1:0]   dst_port;
		logic [NIBBLE_W-1:0] tcp_header_words;
		logic [BYTE_W-1:0]   tcp_flags;
		logic [CIDX_W-1:0]   counter_index;
	} in_item_t;

	// Classified command handed to the counter bank
	typedef struct packed {
		logic              is_read;
		class_t            pkt_class;
		logic [LEN_W-1:0]  payload_length;
		logic [LEN_W-1:0]  total_length;
		logic [BYTE_W-1:0] tcp_flags;
		logic [CIDX_W-1:0] counter_index;
	} cmd_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/tcphf_front.sv
// Front end: filter registers and per-request header classification.
module tcphf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tcphf_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tcphf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  tcphf_pkg::in_item_t             item,
	output tcphf_pkg::cmd_t                 cmd
);
	import tcphf_pkg::*;

	logic [ADDR_W-1:0] flt_src_addr_q;
	logic [ADDR_W-1:0] flt_dst_addr_q;
	logic [PORT_W-1:0] flt_src_port_q;
	logic [PORT_W-1:0] flt_dst_port_q;

	logic [5:0]        ip_len;
	logic [5:0]        tcp_len;
	logic [6:0]        hdr_sum;
	logic [BYTE_W-1:0] cap_need;
	logic              addr_ok;
	logic              port_ok;
	class_t            pkt_class;

	// Hold the filter registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flt_src_addr_q <= '0;
			flt_dst_addr_q <= '0;
			flt_src_port_q <= '0;
			flt_dst_port_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SRC_ADDR: flt_src_addr_q <= cfg_data;
				REG_DST_ADDR: flt_dst_addr_q <= cfg_data;
				REG_SRC_PORT: flt_src_port_q <= cfg_data[PORT_W-1:0];
				REG_DST_PORT: flt_dst_port_q <= cfg_data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	// Header lengths in bytes and the match terms
	assign ip_len   = {item.version_and_ihl[NIBBLE_W-1:0], 2'b00};
	assign tcp_len  = {item.tcp_header_words, 2'b00};
	assign hdr_sum  = {1'b0, ip_len} + {1'b0, tcp_len};
	assign cap_need = {2'b00, ip_len} + BASE_HDR_BYTES;
	assign addr_ok  = (flt_src_addr_q == '0 || item.src_addr == flt_src_addr_q) &&
	                  (flt_dst_addr_q == '0 || item.dst_addr == flt_dst_addr_q);
	assign port_ok  = (flt_src_port_q == '0 || item.src_port == flt_src_port_q) &&
	                  (flt_dst_port_q == '0 || item.dst_port == flt_dst_port_q);

	// Classify in the order the checks take precedence
	always_comb begin
		if (item.captured_length < BASE_HDR_BYTES) begin
			pkt_class = CLASS_IGNORED;
		end else if (item.version_and_ihl[BYTE_W-1:NIBBLE_W] != IP_VERSION_4 ||
		             item.ip_protocol != PROTO_TCP) begin
			pkt_class = CLASS_IGNORED;
		end else if (!addr_ok) begin
			pkt_class = CLASS_FILTERED;
		end else if ({2'b00, ip_len} < BASE_HDR_BYTES || item.captured_length < cap_need) begin
			pkt_class = CLASS_MALFORMED;
		end else if (!port_ok) begin
			pkt_class = CLASS_FILTERED;
		end else if ({2'b00, tcp_len} < BASE_HDR_BYTES ||
		             item.total_length < {9'd0, hdr_sum}) begin
			pkt_class = CLASS_MALFORMED;
		end else begin
			pkt_class = CLASS_COUNTED;
		end
	end

	// Build the command for the counter bank
	always_comb begin
		cmd.is_read        = (item.opcode == OP_READ);
		cmd.pkt_class      = cmd.is_read ? CLASS_IGNORED : pkt_class;
		cmd.payload_length = (cmd.pkt_class == CLASS_COUNTED) ?
		                     (item.total_length - {9'd0, hdr_sum}) : '0;
		cmd.total_length   = item.total_length;
		cmd.tcp_flags      = item.tcp_flags;
		cmd.counter_index  = item.counter_index;
	end

endmodule

>>> rtl/tcphf_queue.sv
// Short command queue that decouples the classifier from the counter bank.
module tcphf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tcphf_pkg::cmd_t        push_cmd,
	input  logic                   pop,
	output tcphf_pkg::cmd_t        head_cmd,
	output tcphf_pkg::q_status_t   status
);
	import tcphf_pkg::*;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_cmd     = entry_q[rd_ptr_q];
	assign status.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

>>> rtl/tcphf_back.sv
// Back end: statistics counter bank and the registered result stage.
module tcphf_back #(
	parameter int unsigned COUNTER_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcphf_pkg::cmd_t               cmd,
	input  logic                          cmd_avail,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tcphf_pkg::class_t             out_class,
	output logic [tcphf_pkg::LEN_W-1:0]   out_payload,
	output logic [tcphf_pkg::VALUE_W-1:0] out_value
);
	import tcphf_pkg::*;

	localparam logic [COUNTER_WIDTH-1:0] ONE = COUNTER_WIDTH'(1);

	logic [COUNTER_WIDTH-1:0] cnt_q [NUM_COUNTERS];
	logic [COUNTER_WIDTH-1:0] cnt_d [NUM_COUNTERS];
	logic                     out_valid_q;
	class_t                   out_class_q;
	logic [LEN_W-1:0]         out_payload_q;
	logic [VALUE_W-1:0]       out_value_q;
	logic [VALUE_W-1:0]       read_value;

	// Take the next command when the result register is free or draining
	assign cmd_pop = cmd_avail && (!out_valid_q || out_ready);

	// Select the counter for a read request
	always_comb begin
		if (cmd.counter_index < CIDX_W'(NUM_COUNTERS)) begin
			read_value = VALUE_W'(cnt_q[cmd.counter_index]);
		end else begin
			read_value = '0;
		end
	end

	// Next counter values for a header request
	always_comb begin
		cnt_d = cnt_q;
		if (cmd_pop && !cmd.is_read) begin
			cnt_d[C_SEEN] = cnt_q[C_SEEN] + ONE;
			unique case (cmd.pkt_class)
				CLASS_FILTERED: cnt_d[C_FILTERED] = cnt_q[C_FILTERED] + ONE;
				CLASS_MALFORMED: cnt_d[C_MALFORMED] = cnt_q[C_MALFORMED] + ONE;
				CLASS_COUNTED: begin
					cnt_d[C_TCP]     = cnt_q[C_TCP] + ONE;
					cnt_d[C_IPBYTES] = cnt_q[C_IPBYTES] + COUNTER_WIDTH'(cmd.total_length);
					cnt_d[C_PAYLOAD] = cnt_q[C_PAYLOAD] + COUNTER_WIDTH'(cmd.payload_length);
					if (cmd.tcp_flags[FLAG_SYN]) cnt_d[C_SYN] = cnt_q[C_SYN] + ONE;
					if (cmd.tcp_flags[FLAG_ACK]) cnt_d[C_ACK] = cnt_q[C_ACK] + ONE;
					if (cmd.tcp_flags[FLAG_FIN]) cnt_d[C_FIN] = cnt_q[C_FIN] + ONE;
					if (cmd.tcp_flags[FLAG_RST]) cnt_d[C_RST] = cnt_q[C_RST] + ONE;
					if (cmd.tcp_flags[FLAG_PSH]) cnt_d[C_PSH] = cnt_q[C_PSH] + ONE;
				end
				CLASS_IGNORED: ;
				default: ;
			endcase
		end
	end

	// Hold the counter bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_class_q   <= cmd.pkt_class;
			out_payload_q <= cmd.payload_length;
			out_value_q   <= cmd.is_read ? read_value : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_class   = out_class_q;
	assign out_payload = out_payload_q;
	assign out_value   = out_value_q;

endmodule

>>> rtl/tcp_header_filter_counters_top.sv
// Top level of the TCP header filter with statistics counters.
// Accepts one request per clock: a parsed IPv4/TCP header is classified as
// ignored, filtered, malformed or counted and updates eleven wrapping
// statistics counters; a read request returns one counter. Each request gives
// exactly one result, registered in the command queue and then in the result
// stage before it is presented. Each header request does a read-modify-write
// of the counter bank. A four-entry command queue lets the input keep flowing
// while the output is stalled, and s_axis_tready drops only when that queue is
// full. Filter registers are written through cfg_we/cfg_addr/cfg_data; the
// user must do so only while idle, which the block itself does not enforce.
module tcp_header_filter_counters_top #(
	parameter int unsigned COUNTER_WIDTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tcphf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [tcphf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// captured_length, version_and_ihl, ip_protocol, src_addr, dst_addr,
	// total_length, src_port, dst_port, tcp_header_words, tcp_flags, counter_index
	input  logic [tcphf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// opcode
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// payload_length, counter_value
	output logic [tcphf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// packet_class
	output logic [1:0]                            m_axis_tuser
);
	import tcphf_pkg::*;

	in_item_t  item;
	cmd_t      front_cmd;
	cmd_t      head_cmd;
	q_status_t q_st;
	logic      push;
	logic      pop;
	class_t    out_class;
	logic [LEN_W-1:0]   out_payload;
	logic [VALUE_W-1:0] out_value;

	// Unpack the request
	assign item.opcode           = s_axis_tuser;
	assign item.captured_length  = s_axis_tdata[7:0];
	assign item.version_and_ihl  = s_axis_tdata[15:8];
	assign item.ip_protocol      = s_axis_tdata[23:16];
	assign item.src_addr         = s_axis_tdata[55:24];
	assign item.dst_addr         = s_axis_tdata[87:56];
	assign item.total_length     = s_axis_tdata[103:88];
	assign item.src_port         = s_axis_tdata[119:104];
	assign item.dst_port         = s_axis_tdata[135:120];
	assign item.tcp_header_words = s_axis_tdata[139:136];
	assign item.tcp_flags        = s_axis_tdata[147:140];
	assign item.counter_index    = s_axis_tdata[151:148];

	assign s_axis_tready = !q_st.full;
	assign push          = s_axis_tvalid && s_axis_tready;

	tcphf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (front_cmd)
	);

	tcphf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_st)
	);

	tcphf_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head_cmd),
		.cmd_avail   (!q_st.empty),
		.cmd_pop     (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_class   (out_class),
		.out_payload (out_payload),
		.out_value   (out_value)
	);

	// Pack the result
	assign m_axis_tdata = {out_value, out_payload};
	assign m_axis_tuser = out_class;

	// A request never enters a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.full |-> !push)
		else $error("request accepted while queue full");

	// Payload is reported only for counted packets
	a_payload_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != CLASS_COUNTED |-> m_axis_tdata[15:0] == '0)
		else $error("payload on a packet that was not counted");

	// A counter value comes only with a read result
	a_value_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[79:16] != '0 |-> m_axis_tuser == CLASS_IGNORED)
		else $error("counter value on a header result");

	// A queued command reaches the output when it is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!q_st.empty && !m_axis_tvalid |=> m_axis_tvalid)
		else $error("queued command not moved to the output");

endmodule

>>> sim/tb_tcp_header_filter_counters_top.sv
// Self-checking testbench for the TCP header filter with statistics counters.
module tb_tcp_header_filter_counters_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcphf_pkg::*;

	localparam int unsigned CNT_W      = 64;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned PHASE_REQS = 135;
	localparam logic [31:0] FLT_SA     = 32'hC0A8_0001;
	localparam logic [31:0] FLT_DA     = 32'h0A00_0002;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// One expected result: class, payload bytes, counter value
	typedef struct packed {
		class_t            cls;
		logic [LEN_W-1:0]  pay;
		logic [CNT_W-1:0]  val;
	} result_t;

	// Directed row: either a full filter setting or one request
	typedef struct {
		bit          is_cfg;
		logic [31:0] f_sa, f_da, f_sp, f_dp;
		in_item_t    req;
		bit          fixed;
		result_t     want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// captured_length, version_and_ihl, ip_protocol, src_addr, dst_addr,
	// total_length, src_port, dst_port, tcp_header_words, tcp_flags, counter_index
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// opcode
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	// payload_length, counter_value
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// packet_class
	logic [1:0]            m_axis_tuser;

	// Shadow of the filter registers and the counter bank
	logic [31:0]      flt_src_addr = '0;
	logic [31:0]      flt_dst_addr = '0;
	logic [31:0]      flt_src_port = '0;
	logic [31:0]      flt_dst_port = '0;
	logic [CNT_W-1:0] stat_count [NUM_COUNTERS];

	result_t   awaited_results [$];
	result_t   sink_want;
	stim_row_t directed_table [$];

	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned sink_stall = 0;
	int unsigned class_tally [4] = '{0, 0, 0, 0};
	int unsigned read_count = 0;
	int unsigned setting_count = 0;

	always #5 clk = ~clk;

	tcp_header_filter_counters_top #(
		.COUNTER_WIDTH(CNT_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic in_item_t pkt(input logic [7:0] cap, vih, proto,
			input logic [31:0] sa, da, input logic [15:0] tot, sp, dp,
			input logic [3:0] doff, input logic [7:0] flags);
		in_item_t r;
		r = '0;
		r.opcode           = OP_HEADER;
		r.captured_length  = cap;
		r.version_and_ihl  = vih;
		r.ip_protocol      = proto;
		r.src_addr         = sa;
		r.dst_addr         = da;
		r.total_length     = tot;
		r.src_port         = sp;
		r.dst_port         = dp;
		r.tcp_header_words = doff;
		r.tcp_flags        = flags;
		return r;
	endfunction

	function automatic in_item_t rd(input logic [CIDX_W-1:0] idx);
		in_item_t r;
		r = '0;
		r.opcode        = OP_READ;
		r.counter_index = idx;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [31:0] sa, da, sp, dp);
		stim_row_t row;
		row = '{is_cfg: 1'b1, f_sa: sa, f_da: da, f_sp: sp, f_dp: dp,
			req: '0, fixed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic stim_row_t run_row(input in_item_t r);
		stim_row_t row;
		row = '{is_cfg: 1'b0, f_sa: '0, f_da: '0, f_sp: '0, f_dp: '0,
			req: r, fixed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic stim_row_t chk_row(input in_item_t r, input class_t cls,
			input logic [LEN_W-1:0] pay, input logic [CNT_W-1:0] val);
		stim_row_t row;
		row = run_row(r);
		row.fixed = 1'b1;
		row.want  = '{cls: cls, pay: pay, val: val};
		return row;
	endfunction

	// Zero in a filter register matches anything
	function automatic bit filter_hit(input logic [31:0] value, want);
		return want == 32'd0 || value == want;
	endfunction

	// Classify one request and advance the shadow counters
	function automatic result_t predict_classification(input in_item_t r);
		result_t     res;
		int unsigned cap, ip_len, tcp_len, tot, base;
		res     = '{cls: CLASS_IGNORED, pay: '0, val: '0};
		cap     = 32'(r.captured_length);
		ip_len  = 32'(r.version_and_ihl[3:0]) * 4;
		tcp_len = 32'(r.tcp_header_words) * 4;
		tot     = 32'(r.total_length);
		base    = 32'(BASE_HDR_BYTES);
		if (r.opcode == OP_READ) begin
			if (32'(r.counter_index) < NUM_COUNTERS)
				res.val = stat_count[r.counter_index];
			return res;
		end
		stat_count[C_SEEN] += 1;
		if (cap < base)
			return res;
		if (r.version_and_ihl[7:4] != IP_VERSION_4 || r.ip_protocol != PROTO_TCP)
			return res;
		if (!filter_hit(r.src_addr, flt_src_addr) || !filter_hit(r.dst_addr, flt_dst_addr)) begin
			stat_count[C_FILTERED] += 1;
			res.cls = CLASS_FILTERED;
			return res;
		end
		if (ip_len < base || cap < ip_len + base) begin
			stat_count[C_MALFORMED] += 1;
			res.cls = CLASS_MALFORMED;
			return res;
		end
		if (!filter_hit(32'(r.src_port), flt_src_port) ||
				!filter_hit(32'(r.dst_port), flt_dst_port)) begin
			stat_count[C_FILTERED] += 1;
			res.cls = CLASS_FILTERED;
			return res;
		end
		if (tcp_len < base || tot < ip_len + tcp_len) begin
			stat_count[C_MALFORMED] += 1;
			res.cls = CLASS_MALFORMED;
			return res;
		end
		res.cls = CLASS_COUNTED;
		res.pay = 16'(tot - ip_len - tcp_len);
		stat_count[C_TCP]     += 1;
		stat_count[C_IPBYTES] += 64'(tot);
		stat_count[C_PAYLOAD] += 64'(res.pay);
		if (r.tcp_flags[FLAG_SYN]) stat_count[C_SYN] += 1;
		if (r.tcp_flags[FLAG_ACK]) stat_count[C_ACK] += 1;
		if (r.tcp_flags[FLAG_FIN]) stat_count[C_FIN] += 1;
		if (r.tcp_flags[FLAG_RST]) stat_count[C_RST] += 1;
		if (r.tcp_flags[FLAG_PSH]) stat_count[C_PSH] += 1;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got, want);
		$display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Present one request, wait for the handshake, then queue its expected result
	task automatic send_request(input in_item_t r, input bit fixed, input result_t want);
		result_t got;
		int      gap;
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			gap = $urandom_range(18, 1);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.opcode;
		s_axis_tdata  <= {r.counter_index, r.tcp_flags, r.tcp_header_words, r.dst_port,
			r.src_port, r.total_length, r.dst_addr, r.src_addr, r.ip_protocol,
			r.version_and_ihl, r.captured_length};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		got = predict_classification(r);
		awaited_results.push_back(fixed ? want : got);
		if (r.opcode == OP_READ)
			read_count++;
		else
			class_tally[got.cls]++;
	endtask

	// Hold off the sender until every result is back, then let the pipe settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four filter registers and mirror them with port values masked
	task automatic write_filters(input logic [31:0] sa, da, sp, dp);
		logic [CFG_ADDR_W-1:0] regs [4];
		logic [31:0]           vals [4];
		regs = '{REG_SRC_ADDR, REG_DST_ADDR, REG_SRC_PORT, REG_DST_PORT};
		vals = '{sa, da, sp, dp};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we   <= 1'b1;
			cfg_addr <= regs[i];
			cfg_data <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		flt_src_addr = sa;
		flt_dst_addr = da;
		flt_src_port = {16'h0, sp[15:0]};
		flt_dst_port = {16'h0, dp[15:0]};
		setting_count++;
	endtask

	// Result sink with bursts of backpressure
	always @(posedge clk) begin
		if (sink_stall != 0) begin
			sink_stall    <= sink_stall - 1;
			m_axis_tready <= (sink_stall == 1);
		end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
			sink_stall    <= $urandom_range(18, 1);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing expected", m_axis_tdata[79:16], 64'd0);
			end else begin
				sink_want = awaited_results.pop_front();
				if (m_axis_tuser != sink_want.cls)
					report_mismatch("packet_class", 64'(m_axis_tuser), 64'(sink_want.cls));
				if (m_axis_tdata[15:0] != sink_want.pay)
					report_mismatch("payload_length", 64'(m_axis_tdata[15:0]), 64'(sink_want.pay));
				if (m_axis_tdata[79:16] != sink_want.val)
					report_mismatch("counter_value", m_axis_tdata[79:16], sink_want.val);
			end
		end
	end

	// Abort when no request or result moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("No handshake for %0d cycles", IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		in_item_t     r;
		logic [159:0] noise;
		logic [31:0]  sa, da, sp, dp;
		int           kind, ihl, doff, hdr, phase, n;

		for (int i = 0; i < NUM_COUNTERS; i++)
			stat_count[i] = '0;

		// Reset counters read zero, each ignore reason, header extremes
		directed_table.push_back(chk_row(rd(C_SEEN), CLASS_IGNORED, 0, 0));
		directed_table.push_back(chk_row(rd(4'hF), CLASS_IGNORED, 0, 0));
		directed_table.push_back(chk_row(pkt(0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			CLASS_IGNORED, 0, 0));
		directed_table.push_back(chk_row(pkt(19, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			40, 80, 443, 5, 0), CLASS_IGNORED, 0, 0));
		directed_table.push_back(chk_row(pkt(255, 8'h55, PROTO_TCP, FLT_SA, FLT_DA,
			1500, 80, 443, 5, 0), CLASS_IGNORED, 0, 0));
		directed_table.push_back(chk_row(pkt(60, 8'h45, PROTO_UDP, FLT_SA, FLT_DA,
			1500, 80, 443, 5, 0), CLASS_IGNORED, 0, 0));
		directed_table.push_back(chk_row(pkt(40, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			40, 80, 443, 5, 0), CLASS_COUNTED, 0, 0));
		directed_table.push_back(run_row(pkt(255, 8'h4F, PROTO_TCP, '1, '1,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 8'hFF)));
		// Each malformed reason on its own
		directed_table.push_back(chk_row(pkt(255, 8'h44, PROTO_TCP, FLT_SA, FLT_DA,
			1500, 80, 443, 5, 0), CLASS_MALFORMED, 0, 0));
		directed_table.push_back(chk_row(pkt(39, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			1500, 80, 443, 5, 0), CLASS_MALFORMED, 0, 0));
		directed_table.push_back(chk_row(pkt(255, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			1500, 80, 443, 4, 0), CLASS_MALFORMED, 0, 0));
		directed_table.push_back(chk_row(pkt(255, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			39, 80, 443, 5, 0), CLASS_MALFORMED, 0, 0));
		directed_table.push_back(run_row(pkt(54, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			1500, 1234, 80, 5, 8'h12)));
		directed_table.push_back(run_row(rd(C_TCP)));
		directed_table.push_back(run_row(rd(C_PAYLOAD)));
		// Filters on: each mismatch, and the order of the checks
		directed_table.push_back(cfg_row(FLT_SA, FLT_DA, 32'h0000_FFFF, 32'h0000_0001));
		directed_table.push_back(chk_row(pkt(60, 8'h45, PROTO_TCP, 32'hC0A8_0002, FLT_DA,
			40, 16'hFFFF, 1, 5, 0), CLASS_FILTERED, 0, 0));
		directed_table.push_back(chk_row(pkt(60, 8'h45, PROTO_TCP, FLT_SA, 32'h0A00_0003,
			40, 16'hFFFF, 1, 5, 0), CLASS_FILTERED, 0, 0));
		directed_table.push_back(chk_row(pkt(60, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			40, 16'hFFFE, 1, 5, 0), CLASS_FILTERED, 0, 0));
		directed_table.push_back(chk_row(pkt(60, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			40, 16'hFFFF, 2, 5, 0), CLASS_FILTERED, 0, 0));
		directed_table.push_back(chk_row(pkt(60, 8'h44, PROTO_TCP, 32'h0, FLT_DA,
			40, 16'hFFFF, 1, 5, 0), CLASS_FILTERED, 0, 0));
		directed_table.push_back(chk_row(pkt(60, 8'h44, PROTO_TCP, FLT_SA, FLT_DA,
			40, 16'h0, 1, 5, 0), CLASS_MALFORMED, 0, 0));
		directed_table.push_back(chk_row(pkt(60, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			40, 16'h0, 1, 4, 0), CLASS_FILTERED, 0, 0));
		directed_table.push_back(run_row(pkt(60, 8'h45, PROTO_TCP, FLT_SA, FLT_DA,
			100, 16'hFFFF, 1, 5, 8'h0D)));
		directed_table.push_back(run_row(rd(C_FILTERED)));
		directed_table.push_back(run_row(rd(C_MALFORMED)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_table[i]) begin
			if (directed_table[i].is_cfg) begin
				wait_idle();
				write_filters(directed_table[i].f_sa, directed_table[i].f_da,
					directed_table[i].f_sp, directed_table[i].f_dp);
			end else begin
				send_request(directed_table[i].req, directed_table[i].fixed,
					directed_table[i].want);
			end
		end

		// Random phases, one filter setting each; the last one without idling
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				1: begin
					sa = $urandom; da = '0; sp = $urandom | 32'h1; dp = '0;
				end
				2: begin
					sa = '1; da = '1; sp = '1; dp = '1;
				end
				3: begin
					sa = 32'h1; da = $urandom | 32'h1; sp = 32'h1;
					dp = 32'($urandom_range(65535, 1));
				end
				default: begin
					sa = '0; da = '0; sp = '0; dp = '0;
				end
			endcase
			wait_idle();
			write_filters(sa, da, sp, dp);
			for (n = 0; n < PHASE_REQS; n++) begin
				if (n % 45 == 0) begin
					src_idle_pct  = (phase == 4) ? 0 : 32'($urandom_range(2)) * 12;
					sink_idle_pct = (phase == 4) ? 0 : 32'($urandom_range(2)) * 12;
				end
				noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
				r = noise[152:0];
				r.opcode = OP_HEADER;
				kind = $urandom_range(99);
				if (kind < 15) begin
					// Counter read, mostly valid indexes
					r.opcode = OP_READ;
					if ($urandom_range(3) != 0)
						r.counter_index = 4'($urandom_range(NUM_COUNTERS - 1));
				end else if (kind < 88) begin
					// Well-formed header with random content
					ihl  = $urandom_range(15, 5);
					doff = $urandom_range(15, 5);
					hdr  = (ihl + doff) * 4;
					r.version_and_ihl  = {IP_VERSION_4, 4'(ihl)};
					r.ip_protocol      = PROTO_TCP;
					r.tcp_header_words = 4'(doff);
					r.captured_length  = 8'($urandom_range(255, ihl * 4 + 20));
					if ($urandom_range(9) == 0)
						r.total_length = 16'($urandom_range(65535, hdr));
					else
						r.total_length = 16'(hdr + $urandom_range(1460));
					if (flt_src_addr != 0 && $urandom_range(9) < 8) r.src_addr = flt_src_addr;
					if (flt_dst_addr != 0 && $urandom_range(9) < 8) r.dst_addr = flt_dst_addr;
					if (flt_src_port != 0 && $urandom_range(9) < 8)
						r.src_port = flt_src_port[15:0];
					if (flt_dst_port != 0 && $urandom_range(9) < 8)
						r.dst_port = flt_dst_port[15:0];
					// Break one length check now and then
					if (kind >= 76) begin
						case ($urandom_range(3))
							0: r.version_and_ihl[3:0] = 4'($urandom_range(4));
							1: r.captured_length = 8'($urandom_range(ihl * 4 + 19, 20));
							2: r.tcp_header_words = 4'($urandom_range(4));
							default: r.total_length = 16'($urandom_range(hdr - 1));
						endcase
					end
				end
				send_request(r, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Covered %0d requests: %0d counted, %0d filtered, %0d malformed, %0d ignored, %0d reads",
			read_count + class_tally[0] + class_tally[1] + class_tally[2] + class_tally[3],
			class_tally[CLASS_COUNTED], class_tally[CLASS_FILTERED],
			class_tally[CLASS_MALFORMED], class_tally[CLASS_IGNORED], read_count);
		$display("Filter settings applied: %0d; mismatches: %0d", setting_count, error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
rtl/tcphf_pkg.sv
rtl/tcphf_front.sv
rtl/tcphf_queue.sv
rtl/tcphf_back.sv
rtl/tcp_header_filter_counters_top.sv
sim/tb_tcp_header_filter_counters_top.sv
